>>> hdl/wfg_pkg.sv
// Package for the wait-for-graph deadlock detector.
// Holds field widths, operation, status and result codes, and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package wfg_pkg;

    localparam int DEF_AGENTS = 8;
    localparam int AGENT_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int BLK_W      = 8;
    localparam int KIND_W     = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OTHER = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STOP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CYCLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOPPED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic capture;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

>>> hdl/wfg_if.sv
// Valid/ready channel interfaces for the deadlock detector input and result items.
// Depends on wfg_pkg for the field widths.
`timescale 1ns / 1ps

interface wfg_in_if import wfg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [AGENT_W-1:0]  agent;
    logic [STATUS_W-1:0] status;
    logic                yield_parked;
    logic [BLK_W-1:0]    blocker_bits;

    modport source(output valid, op, agent, status, yield_parked, blocker_bits,
                   input ready);
    modport sink(input valid, op, agent, status, yield_parked, blocker_bits,
                 output ready);
endinterface

interface wfg_out_if import wfg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BLK_W-1:0]   member_mask;
    logic [AGENT_W-1:0] victim;
    logic               victim_valid;

    modport source(output valid, kind, member_mask, victim, victim_valid,
                   input ready);
    modport sink(input valid, kind, member_mask, victim, victim_valid,
                 output ready);
endinterface

>>> hdl/wfg_dp.sv
// Datapath: agent register file, frontier registers for the reachability search,
// result selection and the output register. Depends on wfg_pkg.
`timescale 1ns / 1ps

module wfg_dp import wfg_pkg::*; #(
    parameter int AGENTS = DEF_AGENTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [AGENT_W-1:0]  i_agent,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_yield_parked,
    input  logic [BLK_W-1:0]    i_blocker_bits,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [KIND_W-1:0]   o_kind,
    output logic [BLK_W-1:0]    o_member_mask,
    output logic [AGENT_W-1:0]  o_victim,
    output logic                o_victim_valid
);

    localparam int IW = $clog2(AGENTS);

    logic                r_manual_stop_blocks;
    logic [STATUS_W-1:0] r_status   [AGENTS];
    logic                r_parked   [AGENTS];
    logic [BLK_W-1:0]    r_blockers [AGENTS];

    logic [AGENTS-1:0] r_fwd, n_fwd;
    logic [AGENTS-1:0] r_bwd, n_bwd;
    logic [IW-1:0]     r_idx;
    logic              r_in_range;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BLK_W-1:0]  r_member_mask;
    logic [AGENT_W-1:0] r_victim;
    logic              r_victim_valid;

    logic [IW-1:0]     w_idx;
    logic              w_in_range;
    logic [AGENTS-1:0] w_idx_bit;
    logic [AGENTS-1:0] w_wait;
    logic [AGENTS-1:0] w_stop;
    logic [AGENTS-1:0] w_adj [AGENTS];
    logic [AGENTS-1:0] w_self [AGENTS];
    logic [AGENTS+BLK_W-1:0] w_wide [AGENTS];

    logic [AGENTS-1:0]       w_sb;
    logic                    w_start_ok;
    logic [AGENTS-1:0]       w_cycle;
    logic [AGENTS+BLK_W-1:0] w_start_wide;
    logic [AGENTS-1:0]       w_blk;
    logic                    w_is_cycle;
    logic                    w_is_stop;
    logic [AGENTS-1:0]       w_members;
    logic [AGENTS-1:0]       w_vsrc;
    logic [IW-1:0]           w_first;
    logic [KIND_W-1:0]       w_kind;
    logic [AGENTS+BLK_W-1:0] w_members_wide;
    logic [IW+AGENT_W-1:0]   w_victim_wide;

    assign w_idx      = IW'(i_agent);
    assign w_in_range = int'(i_agent) < AGENTS;

    always_comb begin
        w_idx_bit        = '0;
        w_idx_bit[w_idx] = 1'b1;
        w_sb             = '0;
        w_sb[r_idx]      = 1'b1;
    end

    always_comb begin
        for (int i = 0; i < AGENTS; i++) begin
            w_wait[i]    = r_status[i] == ST_WAIT;
            w_stop[i]    = (r_status[i] == ST_STOP) && (r_manual_stop_blocks || r_parked[i]);
            w_wide[i]    = {{AGENTS{1'b0}}, r_blockers[i]};
            w_self[i]    = '0;
            w_self[i][i] = 1'b1;
        end
        for (int i = 0; i < AGENTS; i++) begin
            w_adj[i] = w_wait[i] ? (w_wide[i][AGENTS-1:0] & w_wait & ~w_self[i]) : '0;
        end
    end

    always_comb begin
        n_fwd = r_fwd;
        for (int i = 0; i < AGENTS; i++) begin
            if (r_fwd[i]) begin
                n_fwd = n_fwd | w_adj[i];
            end
            n_bwd[i] = r_bwd[i] | (|(w_adj[i] & r_bwd));
        end
    end

    always_comb begin
        w_start_ok   = r_in_range && w_wait[r_idx];
        w_cycle      = r_fwd & r_bwd & w_wait;
        w_start_wide = {{AGENTS{1'b0}}, r_blockers[r_idx]};
        w_blk        = w_start_wide[AGENTS-1:0] & w_stop;
        w_is_cycle   = w_start_ok && ((w_cycle & ~w_sb) != '0);
        w_is_stop    = w_start_ok && !w_is_cycle && (w_blk != '0);
        priority if (w_is_cycle) begin
            w_kind    = KIND_CYCLE;
            w_members = w_cycle;
            w_vsrc    = w_cycle;
        end else if (w_is_stop) begin
            w_kind    = KIND_STOPPED;
            w_members = w_blk | w_sb;
            w_vsrc    = w_blk;
        end else begin
            w_kind    = KIND_NONE;
            w_members = '0;
            w_vsrc    = '0;
        end
        w_first = '0;
        for (int i = AGENTS - 1; i >= 0; i--) begin
            if (w_vsrc[i]) begin
                w_first = IW'(i);
            end
        end
        w_members_wide = {{BLK_W{1'b0}}, w_members};
        w_victim_wide  = {{AGENT_W{1'b0}}, w_first};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_stop_blocks <= 1'b1;
            for (int i = 0; i < AGENTS; i++) begin
                r_status[i]   <= ST_OTHER;
                r_parked[i]   <= 1'b0;
                r_blockers[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_manual_stop_blocks <= i_cfg_wdata;
            end
            if (i_cmd.load && w_in_range) begin
                r_status[w_idx]   <= i_status;
                r_parked[w_idx]   <= i_yield_parked;
                r_blockers[w_idx] <= i_blocker_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx      <= w_idx;
            r_in_range <= w_in_range;
            r_fwd      <= w_idx_bit;
            r_bwd      <= w_idx_bit;
        end else if (i_cmd.step) begin
            r_fwd <= n_fwd;
            r_bwd <= n_bwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_kind         <= w_kind;
            r_member_mask  <= w_members_wide[BLK_W-1:0];
            r_victim       <= (w_kind != KIND_NONE) ? w_victim_wide[AGENT_W-1:0] : '0;
            r_victim_valid <= w_kind != KIND_NONE;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_member_mask   = r_member_mask;
    assign o_victim        = r_victim;
    assign o_victim_valid  = r_victim_valid;

    property p_vvalid_matches_kind;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_victim_valid == (r_kind != KIND_NONE));
    endproperty
    a_vvalid_matches_kind: assert property (p_vvalid_matches_kind)
        else $error("Victim valid disagrees with the result kind.");

    property p_frontier_grows;
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.step) && !$past(i_cmd.capture) |->
            ((r_fwd & $past(r_fwd)) == $past(r_fwd));
    endproperty
    a_frontier_grows: assert property (p_frontier_grows)
        else $error("Forward reach set lost a member during the search.");

endmodule

>>> hdl/wfg_ctrl.sv
// Controller: state machine and step counter that sequence loads and queries.
// Drives datapath commands and the input ready. Depends on wfg_pkg.
`timescale 1ns / 1ps

module wfg_ctrl import wfg_pkg::*; #(
    parameter int AGENTS = DEF_AGENTS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_op,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam int CW = $clog2(AGENTS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_op == OP_QUERY)) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (r_cnt == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid && (i_op == OP_LOAD);
                o_cmd.capture = i_in_valid && (i_op == OP_QUERY);
            end
            S_CLOSE: begin
                o_cmd.step = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.capture) begin
                r_cnt <= CW'(AGENTS - 2);
            end else if (o_cmd.step && (r_cnt != '0)) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    property p_finish_needs_room;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_stat.out_busy;
    endproperty
    a_finish_needs_room: assert property (p_finish_needs_room)
        else $error("Result written while the output register is still held.");

    property p_query_starts_search;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_CLOSE) && (r_cnt == CW'(AGENTS - 2));
    endproperty
    a_query_starts_search: assert property (p_query_starts_search)
        else $error("Accepted query did not start the search.");

    property p_no_accept_while_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready && !o_cmd.load && !o_cmd.capture;
    endproperty
    a_no_accept_while_busy: assert property (p_no_accept_while_busy)
        else $error("Input transaction taken while a query is in progress.");

endmodule

>>> hdl/wait_for_graph_deadlock_detector_core.sv
// Top level of the wait-for-graph deadlock detector: controller plus datapath.
// Depends on wfg_pkg, wfg_if, wfg_ctrl and wfg_dp.
//
//   Port      Direction  Kind               Contents
//   i_in      in         valid/ready        op, agent, status, yield_parked, blocker_bits
//   o_out     out        valid/ready        kind, member_mask, victim, victim_valid
//   i_cfg_*   in         write enable/data  manual_stop_blocks
//
// A load transaction is taken while the controller is idle and gives no result.
// A query is captured, runs AGENTS - 1 reachability steps, then forms the result once the output
// register is free; the step count is set by AGENTS, not by the wait-for graph.
// Reset is synchronous and clears all agent slots; no clearing pass is needed.
// A held result does not stop loads or the next query until that query's result is ready.
`timescale 1ns / 1ps

module wait_for_graph_deadlock_detector_core import wfg_pkg::*; #(
    parameter int AGENTS = DEF_AGENTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    wfg_in_if.sink    i_in,
    wfg_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    wfg_ctrl #(
        .AGENTS (AGENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    wfg_dp #(
        .AGENTS (AGENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_agent        (i_in.agent),
        .i_status       (i_in.status),
        .i_yield_parked (i_in.yield_parked),
        .i_blocker_bits (i_in.blocker_bits),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_member_mask  (o_out.member_mask),
        .o_victim       (o_out.victim),
        .o_victim_valid (o_out.victim_valid)
    );

endmodule
